>>> hw/rtl/b64e_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b64e_pkg: shared types and constants of the Base64 stream encoder
// Holds the job record that passes from the front end to the back end,
// the queue depth and the Base64 alphabet function.
// ----------------------------------------------------------------------------
package b64e_pkg;

    localparam int QDEPTH = 2;
    localparam int QAW    = $clog2(QDEPTH);

    localparam logic [5:0] GPL_RESET    = 6'd19;
    localparam logic [7:0] PAD_CHAR     = 8'h3D;
    localparam logic [7:0] NEWLINE_CHAR = 8'h0A;

    localparam logic       CMD_DATA  = 1'b0;
    localparam logic       CMD_FLUSH = 1'b1;

    typedef struct packed {
        logic [23:0] grp;
        logic [1:0]  npad;
        logic        nl;
    } job_t;

    function automatic logic [7:0] b64_sym(input logic [5:0] v);
        logic [7:0] r;
        if (v < 6'd26) begin
            r = 8'h41 + {2'b00, v};
        end else if (v < 6'd52) begin
            r = 8'h61 + {2'b00, v} - 8'd26;
        end else if (v < 6'd62) begin
            r = 8'h30 + {2'b00, v} - 8'd52;
        end else if (v == 6'd62) begin
            r = 8'h2B;
        end else begin
            r = 8'h2F;
        end
        return r;
    endfunction

endpackage

>>> hw/rtl/b64e_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b64e_front: input stage of the Base64 stream encoder
// Collects bytes into groups of three, tracks the line position and queues
// one encoding job per complete group or padded flush.
// ----------------------------------------------------------------------------
module b64e_front import b64e_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // data_byte
    input  logic       s_tuser,   // cmd
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [5:0] cfg_data,  // groups_per_line
    input  logic       q_full,
    output logic       q_push,
    output job_t       q_job
);

    logic [1:0] pcnt_reg, pcnt_next;
    logic [7:0] pb0_reg, pb0_next;
    logic [7:0] pb1_reg, pb1_next;
    logic [5:0] gc_reg, gc_next;
    logic [5:0] gpl_reg;
    logic [5:0] gc_inc;
    logic       accept;

    assign s_tready  = !q_full;
    assign cfg_ready = 1'b1;
    assign accept    = s_tvalid && s_tready;
    assign gc_inc    = gc_reg + 6'd1;

    always_comb begin
        pcnt_next = pcnt_reg;
        pb0_next  = pb0_reg;
        pb1_next  = pb1_reg;
        gc_next   = gc_reg;
        q_push    = 1'b0;
        q_job     = '0;
        if (accept) begin
            if (s_tuser == CMD_DATA) begin
                if (pcnt_reg < 2'd2) begin
                    if (pcnt_reg[0]) begin
                        pb1_next = s_tdata;
                    end else begin
                        pb0_next = s_tdata;
                    end
                    pcnt_next = pcnt_reg + 2'd1;
                end else begin
                    q_push     = 1'b1;
                    q_job.grp  = {pb0_reg, pb1_reg, s_tdata};
                    q_job.npad = 2'd0;
                    q_job.nl   = (gc_inc >= gpl_reg);
                    pcnt_next  = 2'd0;
                    gc_next    = q_job.nl ? 6'd0 : gc_inc;
                end
            end else begin
                if (pcnt_reg != 2'd0) begin
                    q_push     = 1'b1;
                    q_job.grp  = {pb0_reg, (pcnt_reg == 2'd2) ? pb1_reg : 8'h00, 8'h00};
                    q_job.npad = (pcnt_reg == 2'd2) ? 2'd1 : 2'd2;
                    q_job.nl   = 1'b0;
                end
                pcnt_next = 2'd0;
                pb0_next  = 8'h00;
                pb1_next  = 8'h00;
                gc_next   = 6'd0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        pb0_reg <= pb0_next;
        pb1_reg <= pb1_next;
        if (!aresetn) begin
            pcnt_reg <= 2'd0;
            gc_reg   <= 6'd0;
            gpl_reg  <= GPL_RESET;
        end else begin
            pcnt_reg <= pcnt_next;
            gc_reg   <= gc_next;
            if (cfg_valid && cfg_ready) begin
                gpl_reg <= cfg_data;
            end
        end
    end

endmodule

>>> hw/rtl/b64e_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b64e_queue: job queue of the Base64 stream encoder
// A short first-in first-out buffer that decouples the input stage from
// the character output stage.
// ----------------------------------------------------------------------------
module b64e_queue import b64e_pkg::*; (
    input  logic aclk,
    input  logic aresetn,
    input  logic push,
    input  job_t push_job,
    output logic full,
    input  logic pop,
    output logic valid,
    output job_t head
);

    job_t             mem [QDEPTH];
    logic [QAW-1:0]   wptr_reg, rptr_reg;
    logic [QAW:0]     cnt_reg;

    assign full  = (cnt_reg == (QAW+1)'(QDEPTH));
    assign valid = (cnt_reg != '0);
    assign head  = mem[rptr_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wptr_reg] <= push_job;
        end
        if (!aresetn) begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            cnt_reg  <= '0;
        end else begin
            if (push) begin
                wptr_reg <= wptr_reg + 1'b1;
            end
            if (pop) begin
                rptr_reg <= rptr_reg + 1'b1;
            end
            if (push && !pop) begin
                cnt_reg <= cnt_reg + 1'b1;
            end else if (pop && !push) begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

endmodule

>>> hw/rtl/b64e_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b64e_back: output stage of the Base64 stream encoder
// Takes one job at a time from the queue and sends its four characters,
// padding and optional newline via an output register, one per ready cycle.
// ----------------------------------------------------------------------------
module b64e_back import b64e_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       q_valid,
    input  job_t       q_head,
    output logic       q_pop,
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // out_char
    output logic       m_tlast    // last_char
);

    job_t       job_reg, job_next;
    logic [2:0] idx_reg, idx_next;
    logic       busy_reg, busy_next;
    logic       ov_reg, ov_next;
    logic [7:0] och_reg, och_next;
    logic       olast_reg, olast_next;

    job_t       cur;
    logic [2:0] cidx;
    logic       can_load;
    logic       emit;
    logic [5:0] sext;
    logic [7:0] ch;
    logic       last;

    assign can_load = !ov_reg || m_tready;
    assign q_pop    = !busy_reg && q_valid && can_load;
    assign emit     = can_load && (busy_reg || q_valid);
    assign cur      = busy_reg ? job_reg : q_head;
    assign cidx     = busy_reg ? idx_reg : 3'd0;

    always_comb begin
        case (cidx[1:0])
            2'd0:    sext = cur.grp[23:18];
            2'd1:    sext = cur.grp[17:12];
            2'd2:    sext = cur.grp[11:6];
            default: sext = cur.grp[5:0];
        endcase
        if (cidx == 3'd4) begin
            ch = NEWLINE_CHAR;
        end else if ({1'b0, cidx} >= (4'd4 - {2'b00, cur.npad})) begin
            ch = PAD_CHAR;
        end else begin
            ch = b64_sym(sext);
        end
        last = cur.nl ? (cidx == 3'd4) : (cidx == 3'd3);
    end

    always_comb begin
        job_next   = job_reg;
        idx_next   = idx_reg;
        busy_next  = busy_reg;
        ov_next    = ov_reg;
        och_next   = och_reg;
        olast_next = olast_reg;
        if (can_load) begin
            ov_next = emit;
        end
        if (emit) begin
            och_next   = ch;
            olast_next = last;
            job_next   = cur;
            idx_next   = cidx + 3'd1;
            busy_next  = !last;
        end
    end

    always_ff @(posedge aclk) begin
        job_reg   <= job_next;
        idx_reg   <= idx_next;
        och_reg   <= och_next;
        olast_reg <= olast_next;
        if (!aresetn) begin
            busy_reg <= 1'b0;
            ov_reg   <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            ov_reg   <= ov_next;
        end
    end

    assign m_tvalid = ov_reg;
    assign m_tdata  = och_reg;
    assign m_tlast  = olast_reg;

endmodule

>>> hw/rtl/base64_stream_encoder_unit.sv
`timescale 1ns / 1ps
// A group's first character is registered in the job queue, then in the output register.
// Throughput: one input request per cycle while the two-entry job queue has room.
// The output stage sends one character per cycle while m_tready is high,
// with no gap between jobs; three bytes give four characters, or five with a newline.
// Reset is synchronous and active low; it empties the queue and sets groups_per_line to 19.
// ----------------------------------------------------------------------------
// base64_stream_encoder_unit: streaming Base64 encoder with line wrap
// Front end groups bytes, a job queue decouples it from the back end,
// which serializes Base64 characters, padding and newlines.
// ----------------------------------------------------------------------------
module base64_stream_encoder_unit import b64e_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // data_byte
    input  logic       s_tuser,   // cmd
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // out_char
    output logic       m_tlast,   // last_char
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [5:0] cfg_data   // groups_per_line
);

    logic q_full, q_push, q_pop, q_valid;
    job_t q_job, q_head;

    b64e_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_job     (q_job)
    );

    b64e_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (q_push),
        .push_job (q_job),
        .full     (q_full),
        .pop      (q_pop),
        .valid    (q_valid),
        .head     (q_head)
    );

    b64e_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_valid  (q_valid),
        .q_head   (q_head),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule

>>> hw/rtl/b64e_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b64e_checker: port-level checks of the Base64 stream encoder
// Watches the result channel for hold, reset, newline and padding rules.
// ----------------------------------------------------------------------------
module b64e_checker import b64e_pkg::*; (
    input logic       aclk,
    input logic       aresetn,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata,
    input logic       m_tlast
);

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("result changed while stalled");

    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    a_newline_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tdata == NEWLINE_CHAR) |-> m_tlast)
        else $error("newline not last character of its request");

    a_pad_pair: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tready && (m_tdata == PAD_CHAR) && !m_tlast
        |=> m_tvalid && (m_tdata == PAD_CHAR) && m_tlast)
        else $error("padding sequence broken");

endmodule

bind base64_stream_encoder_unit b64e_checker u_b64e_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);

>>> tb/tb_base64_stream_encoder_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_base64_stream_encoder_unit: self-checking bench for the Base64 encoder
// Drives bytes and flush requests through the input stream in random bursts.
// It predicts every character, padding and newline from its own copy of the
// encoder state, and checks each character and its end flag while the output
// side stalls on a rotating pattern. The line length register is exercised
// at its extremes, at zero, and when it is lowered under the running count.
// ----------------------------------------------------------------------------
module tb_base64_stream_encoder_unit;
    import b64e_pkg::*;

    localparam string B64_ALPHABET =
        "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

    typedef struct {
        logic [7:0] ch;
        logic       is_last;
    } enc_char_t;

    logic       aclk = 1'b0;
    logic       aresetn;
    logic       s_tvalid;
    logic       s_tready;
    logic [7:0] s_tdata;   // data_byte
    logic       s_tuser;   // cmd
    logic       m_tvalid;
    logic       m_tready = 1'b0;
    logic [7:0] m_tdata;   // out_char
    logic       m_tlast;   // last_char
    logic       cfg_valid;
    logic       cfg_ready;
    logic [5:0] cfg_data;  // groups_per_line

    enc_char_t  char_q[$];
    logic [1:0] held_cnt;
    logic [7:0] held_byte[2];
    logic [5:0] line_groups;
    logic [5:0] gpl_shadow;
    int         mismatches;
    int         burst_left;
    bit         gaps_on;
    bit         stall_on;
    logic [15:0] ready_pat = 16'hB5A3;

    base64_stream_encoder_unit dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always #5 aclk = ~aclk;

    always @(posedge aclk) begin
        if (!stall_on) begin
            m_tready <= 1'b1;
        end else begin
            m_tready <= ready_pat[0];
            if ($urandom_range(0, 47) == 0) begin
                ready_pat <= ($urandom_range(0, 3) == 0) ? 16'hFFFF
                                                         : (16'($urandom) | 16'h0001);
            end else begin
                ready_pat <= {ready_pat[0], ready_pat[15:1]};
            end
        end
    end

    function automatic logic [7:0] b64_char(input logic [5:0] v);
        return B64_ALPHABET[v];
    endfunction

    task automatic note_mismatch(input string what, input int want, input int got);
        mismatches++;
        if (mismatches <= 10) begin
            $display("Mismatch on %s at %0t: expected 0x%02h, got 0x%02h.",
                     what, $time, want, got);
        end
    endtask

    always @(posedge aclk) begin : check_chars
        enc_char_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (char_q.size() == 0) begin
                note_mismatch("unexpected character", 0, m_tdata);
            end else begin
                want = char_q.pop_front();
                if (m_tdata !== want.ch) begin
                    note_mismatch("out_char", want.ch, m_tdata);
                end
                if (m_tlast !== want.is_last) begin
                    note_mismatch("last_char", want.is_last, m_tlast);
                end
            end
        end
    end

    task automatic encode_request(input logic cmd, input logic [7:0] b);
        logic [7:0] out_chars[$];
        logic [7:0] c1;
        logic [7:0] c2;
        c1 = held_byte[0];
        c2 = held_byte[1];
        if (cmd == CMD_DATA) begin
            if (held_cnt < 2'd2) begin
                held_byte[held_cnt[0]] = b;
                held_cnt = held_cnt + 2'd1;
            end else begin
                out_chars.push_back(b64_char(c1[7:2]));
                out_chars.push_back(b64_char({c1[1:0], c2[7:4]}));
                out_chars.push_back(b64_char({c2[3:0], b[7:6]}));
                out_chars.push_back(b64_char(b[5:0]));
                held_cnt = 2'd0;
                line_groups = line_groups + 6'd1;
                if (line_groups >= gpl_shadow) begin
                    out_chars.push_back(NEWLINE_CHAR);
                    line_groups = 6'd0;
                end
            end
        end else begin
            if (held_cnt != 2'd0) begin
                if (held_cnt < 2'd2) begin
                    c2 = 8'h00;
                end
                out_chars.push_back(b64_char(c1[7:2]));
                out_chars.push_back(b64_char({c1[1:0], c2[7:4]}));
                out_chars.push_back((held_cnt >= 2'd2) ? b64_char({c2[3:0], 2'b00}) : PAD_CHAR);
                out_chars.push_back(PAD_CHAR);
            end
            held_cnt = 2'd0;
            held_byte[0] = 8'h00;
            held_byte[1] = 8'h00;
            line_groups = 6'd0;
        end
        foreach (out_chars[i]) begin
            char_q.push_back('{ch: out_chars[i], is_last: (i == out_chars.size() - 1)});
        end
    endtask

    task automatic send_request(input logic cmd, input logic [7:0] b);
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= b;
        do @(posedge aclk); while (!s_tready);
        encode_request(cmd, b);
        if (gaps_on) begin
            if (burst_left == 0) begin
                s_tvalid <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge aclk);
                burst_left = $urandom_range(1, 12);
            end else begin
                burst_left--;
            end
        end
    endtask

    task automatic send_group(input logic [7:0] b0, input logic [7:0] b1, input logic [7:0] b2);
        send_request(CMD_DATA, b0);
        send_request(CMD_DATA, b1);
        send_request(CMD_DATA, b2);
    endtask

    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (char_q.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    task automatic write_line_groups(input logic [5:0] v);
        wait_idle();
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        gpl_shadow = v;
    endtask

    task automatic random_request(input int flush_odds);
        logic [7:0] b;
        logic       cmd;
        case ($urandom_range(0, 9))
            0:       b = 8'h00;
            1:       b = 8'hFF;
            default: b = 8'($urandom_range(0, 255));
        endcase
        cmd = (flush_odds > 0 && $urandom_range(1, flush_odds) == 1) ? CMD_FLUSH : CMD_DATA;
        send_request(cmd, b);
    endtask

    task automatic test_data_extremes();
        send_group(8'h00, 8'h00, 8'h00);
        send_group(8'hFF, 8'hFF, 8'hFF);
        send_group(8'hFB, 8'hEF, 8'hBE);
    endtask

    task automatic test_flush_cases();
        send_request(CMD_FLUSH, 8'hFF);
        send_request(CMD_DATA, 8'hFF);
        send_request(CMD_FLUSH, 8'h00);
        send_request(CMD_DATA, 8'h00);
        send_request(CMD_DATA, 8'hFF);
        send_request(CMD_FLUSH, 8'hA5);
    endtask

    task automatic test_default_line_length();
        repeat (60) random_request(0);
        send_request(CMD_FLUSH, 8'h5A);
    endtask

    task automatic test_line_settings();
        write_line_groups(6'd0);
        send_group(8'h12, 8'h34, 8'h56);
        send_request(CMD_FLUSH, 8'h00);
        write_line_groups(6'd3);
        send_group(8'hDE, 8'hAD, 8'hBE);
        send_request(CMD_FLUSH, 8'hFF);
        send_group(8'hEF, 8'h01, 8'h80);
        send_group(8'h7F, 8'hC3, 8'h3C);
        write_line_groups(6'd1);
        send_group(8'h99, 8'h66, 8'hF0);
    endtask

    task automatic test_random_stream();
        logic [5:0] settings[5];
        settings[0] = 6'd1;
        settings[1] = 6'd63;
        settings[2] = 6'd2;
        settings[3] = 6'($urandom_range(3, 62));
        settings[4] = GPL_RESET;
        for (int p = 0; p < 5; p++) begin
            write_line_groups(settings[p]);
            stall_on = (p != 2);
            gaps_on  = (p != 3);
            repeat (37) random_request(10);
        end
        gaps_on  = 1'b1;
        stall_on = 1'b1;
    endtask

    initial begin
        aresetn   <= 1'b0;
        s_tvalid  <= 1'b0;
        s_tdata   <= 8'h00;
        s_tuser   <= CMD_DATA;
        cfg_valid <= 1'b0;
        cfg_data  <= 6'd0;
        gaps_on    = 1'b1;
        stall_on   = 1'b1;
        burst_left = 0;
        mismatches = 0;
        held_cnt     = 2'd0;
        held_byte[0] = 8'h00;
        held_byte[1] = 8'h00;
        line_groups  = 6'd0;
        gpl_shadow   = GPL_RESET;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_data_extremes();
        test_flush_cases();
        test_default_line_length();
        test_line_settings();
        test_random_stream();

        wait_idle();
        repeat (16) @(posedge aclk);
        if (mismatches == 0 && char_q.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule
